// ----- rtl/sm4_pkg.sv -----
// Package: SM4 constants, S-box, key-schedule helpers and sequencer state type.
package sm4_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_HI      = 3'd0;
  localparam logic [2:0] REG_KEY_LO      = 3'd1;
  localparam logic [2:0] REG_IV_HI       = 3'd2;
  localparam logic [2:0] REG_IV_LO       = 3'd3;
  localparam logic [2:0] REG_CHAIN_MODE  = 3'd4;
  localparam logic [2:0] REG_DECRYPT_DIR = 3'd5;

  localparam int CFG_IDX_W = 3;
  localparam int ROUNDS    = 32;
  localparam int RND_W     = 5;

  // System parameter FK
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_KLOAD,
    ST_KEXP,
    ST_IDLE,
    ST_RND,
    ST_FIN
  } sm4_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution of one word
  function automatic logic [31:0] sub_word(logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // CK word i: byte j is (4i+j)*7 mod 256, first byte most significant
  function automatic logic [31:0] ck_word(logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  base;
    w    = '0;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[31-8*j -: 8] = (base + 8'(j)) * 8'd7;
    end
    return w;
  endfunction

endpackage

// ----- rtl/sm4_if.sv -----
// Interfaces: input block channel, result channel and configuration write channel.
interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic        restart_chain;

  modport source (output valid, block_hi, block_lo, restart_chain, input ready);
  modport sink   (input valid, block_hi, block_lo, restart_chain, output ready);
endinterface

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface sm4_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sm4_round.sv -----
// Shared SM4 round unit: S-box layer plus cipher or key-schedule linear transform.
module sm4_round_unit (
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w2,
  input  logic [31:0] w3,
  input  logic [31:0] rk,
  input  logic        key_sched,
  output logic [31:0] w_new
);

  logic [31:0] s;
  logic [31:0] l_enc;
  logic [31:0] l_key;

  // Nonlinear layer
  assign s = sm4_pkg::sub_word(w1 ^ w2 ^ w3 ^ rk);

  // L: rotations by 2, 10, 18, 24; L': rotations by 13, 23
  assign l_enc = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
                   ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
  assign l_key = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};

  assign w_new = w0 ^ (key_sched ? l_key : l_enc);

endmodule

// ----- rtl/sm4_rkmem.sv -----
// Round key store: 32 x 32-bit memory, one write port, registered read.
module sm4_rkmem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [sm4_pkg::RND_W-1:0]  wr_addr,
  input  logic [31:0]                wr_data,
  input  logic [sm4_pkg::RND_W-1:0]  rd_addr,
  output logic [31:0]                rd_data_r
);

  logic [31:0] rk_mem_r [sm4_pkg::ROUNDS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rk_mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= rk_mem_r[rd_addr];
  end

endmodule

// ----- rtl/sm4_block_cipher_cbc_core.sv -----
// Top level: SM4 ECB/CBC block cipher core with iterative round unit and sequencer.
//
// Usage:
//   cfg_if   register writes (index, data); always ready. Index 0/1 key halves,
//            2/3 IV halves, 4 chain mode (0 ECB, 1 CBC), 5 direction (1 decrypt).
//            Other indexes are ignored. Write only while the core is idle.
//   in_if    one 128-bit block per transfer; restart_chain reloads the chaining
//            value from the IV before this block.
//   out_if   one 128-bit result per input block, held in an output register.
// Sequencing:
//   After reset and after every key write the round keys are expanded (a load
//   state, then 32 key-schedule rounds) with in_if.ready low.
//   A block runs its 32 rounds on the shared round unit, then the finish state
//   registers the result. in_if.ready is high only in the idle state, so a new
//   block is taken only after the previous one has left the finish state.
//   The round key memory read is prefetched one round ahead.
// Reset (rst_n, synchronous): control and configuration registers and chaining
//   value clear to zero, then the all-zero key is expanded.
// Stall: a result waits in the output register; the core finishes the next
//   block and then holds in the finish state until the register is free.
module sm4_block_cipher_cbc_core (
  input  logic       clk,
  input  logic       rst_n,
  sm4_in_if.sink     in_if,
  sm4_out_if.source  out_if,
  sm4_cfg_if.sink    cfg_if
);

  localparam logic [sm4_pkg::RND_W-1:0] LAST_RND = sm4_pkg::RND_W'(sm4_pkg::ROUNDS - 1);

  sm4_pkg::sm4_state_t state_r, state_nxt;
  logic [sm4_pkg::RND_W-1:0] cnt_r, cnt_nxt;

  logic [63:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic        chain_mode_r, decrypt_dir_r;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] blk_r;
  logic [31:0]  x_r [4];
  logic [31:0]  x_nxt [4];
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic        cfg_fire, key_wr, in_fire, slot_free;
  logic        is_idle, is_kexp, is_rnd, is_fin, is_kload;
  logic        fin_fire;
  logic [31:0] round_key, rk_rd, f_out;
  logic [sm4_pkg::RND_W-1:0] rd_idx, rd_addr;
  logic [127:0] in_block, chain_eff, result;

  // Handshakes
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid & cfg_if.ready;
  assign key_wr       = cfg_fire & ((cfg_if.index == sm4_pkg::REG_KEY_HI) ||
                                    (cfg_if.index == sm4_pkg::REG_KEY_LO));
  assign in_fire      = in_if.valid & in_if.ready;
  assign slot_free    = ~out_valid_r | out_if.ready;

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sm4_pkg::ST_KLOAD: state_nxt = sm4_pkg::ST_KEXP;
      sm4_pkg::ST_KEXP:  if (cnt_r == LAST_RND) state_nxt = sm4_pkg::ST_IDLE;
      sm4_pkg::ST_IDLE:  if (in_fire) state_nxt = sm4_pkg::ST_RND;
      sm4_pkg::ST_RND:   if (cnt_r == LAST_RND) state_nxt = sm4_pkg::ST_FIN;
      sm4_pkg::ST_FIN:   if (slot_free) state_nxt = sm4_pkg::ST_IDLE;
      default:           state_nxt = sm4_pkg::ST_KLOAD;
    endcase
    // A new key always restarts the key schedule
    if (key_wr) begin
      state_nxt = sm4_pkg::ST_KLOAD;
    end
  end

  // State decode outputs
  always_comb begin
    is_kload = 1'b0;
    is_kexp  = 1'b0;
    is_idle  = 1'b0;
    is_rnd   = 1'b0;
    is_fin   = 1'b0;
    unique case (state_r)
      sm4_pkg::ST_KLOAD: is_kload = 1'b1;
      sm4_pkg::ST_KEXP:  is_kexp  = 1'b1;
      sm4_pkg::ST_IDLE:  is_idle  = 1'b1;
      sm4_pkg::ST_RND:   is_rnd   = 1'b1;
      sm4_pkg::ST_FIN:   is_fin   = 1'b1;
      default:           is_kload = 1'b0;
    endcase
  end

  assign in_if.ready = is_idle;
  assign fin_fire    = is_fin & slot_free;

  // Round counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (is_kload || is_idle) begin
      cnt_nxt = '0;
    end else if (is_kexp || is_rnd) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Round key memory: written during the key schedule, read one round ahead
  assign rd_idx  = is_rnd ? cnt_r + 1'b1 : '0;
  assign rd_addr = decrypt_dir_r ? ~rd_idx : rd_idx;

  sm4_rkmem u_rkmem (
    .clk       (clk),
    .wr_en     (is_kexp),
    .wr_addr   (cnt_r),
    .wr_data   (f_out),
    .rd_addr   (rd_addr),
    .rd_data_r (rk_rd)
  );

  // Shared round unit
  assign round_key = is_kexp ? sm4_pkg::ck_word(cnt_r) : rk_rd;

  sm4_round_unit u_round (
    .w0        (x_r[0]),
    .w1        (x_r[1]),
    .w2        (x_r[2]),
    .w3        (x_r[3]),
    .rk        (round_key),
    .key_sched (is_kexp),
    .w_new     (f_out)
  );

  // Chaining and block load
  assign chain_eff = in_if.restart_chain ? {iv_hi_r, iv_lo_r} : chain_r;
  assign in_block  = {in_if.block_hi, in_if.block_lo} ^
                     ((chain_mode_r & ~decrypt_dir_r) ? chain_eff : 128'd0);
  assign result    = {x_r[3], x_r[2], x_r[1], x_r[0]} ^
                     ((chain_mode_r & decrypt_dir_r) ? chain_r : 128'd0);

  // Working words
  always_comb begin
    x_nxt = x_r;
    if (is_kload) begin
      x_nxt[0] = key_hi_r[63:32] ^ sm4_pkg::FK0;
      x_nxt[1] = key_hi_r[31:0]  ^ sm4_pkg::FK1;
      x_nxt[2] = key_lo_r[63:32] ^ sm4_pkg::FK2;
      x_nxt[3] = key_lo_r[31:0]  ^ sm4_pkg::FK3;
    end else if (is_idle && in_fire) begin
      x_nxt[0] = in_block[127:96];
      x_nxt[1] = in_block[95:64];
      x_nxt[2] = in_block[63:32];
      x_nxt[3] = in_block[31:0];
    end else if (is_kexp || is_rnd) begin
      x_nxt[0] = x_r[1];
      x_nxt[1] = x_r[2];
      x_nxt[2] = x_r[3];
      x_nxt[3] = f_out;
    end
  end

  // Chaining value update
  always_comb begin
    chain_nxt = chain_r;
    if (in_fire && in_if.restart_chain) begin
      chain_nxt = {iv_hi_r, iv_lo_r};
    end else if (fin_fire && chain_mode_r) begin
      chain_nxt = decrypt_dir_r ? blk_r : result;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_if.ready;
    out_data_nxt  = out_data_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.result_hi = out_data_r[127:64];
  assign out_if.result_lo = out_data_r[63:0];

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= sm4_pkg::ST_KLOAD;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      chain_r       <= '0;
      key_hi_r      <= '0;
      key_lo_r      <= '0;
      iv_hi_r       <= '0;
      iv_lo_r       <= '0;
      chain_mode_r  <= 1'b0;
      decrypt_dir_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
      if (cfg_fire) begin
        unique case (cfg_if.index)
          sm4_pkg::REG_KEY_HI:      key_hi_r      <= cfg_if.data;
          sm4_pkg::REG_KEY_LO:      key_lo_r      <= cfg_if.data;
          sm4_pkg::REG_IV_HI:       iv_hi_r       <= cfg_if.data;
          sm4_pkg::REG_IV_LO:       iv_lo_r       <= cfg_if.data;
          sm4_pkg::REG_CHAIN_MODE:  chain_mode_r  <= cfg_if.data[0];
          sm4_pkg::REG_DECRYPT_DIR: decrypt_dir_r <= cfg_if.data[0];
          default:                  ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      blk_r <= {in_if.block_hi, in_if.block_lo};
    end
  end

  // An accepted block starts the rounds at round zero
  a_start_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !key_wr) |=> (state_r == sm4_pkg::ST_RND && cnt_r == '0))
    else $error("block transfer did not start the round sequence");

  // A key write blocks input until the schedule is rebuilt
  a_key_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> !in_if.ready)
    else $error("input ready right after a key write");

  // A new result appears only from the finish state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sm4_pkg::ST_FIN))
    else $error("result valid raised outside the finish state");

  // The last round leads to the finish state unless a key write intervenes
  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sm4_pkg::ST_RND && cnt_r == LAST_RND && !key_wr)
      |=> state_r == sm4_pkg::ST_FIN)
    else $error("round sequence did not reach the finish state");

endmodule
